>>> design/lgs_pkg.sv
// Shared types, constants and table helper for the loss and gradient stream.
package lgs_pkg;

  // Default parameter values
  localparam int COUNT_BITS_DEF = 24;
  localparam int LOG_DEPTH_DEF  = 256;

  // Fixed datapath widths
  localparam int ACC_W  = 48;
  localparam int TERM_W = 24;

  // ln 2 in Q0.30
  localparam logic signed [31:0] LN2_Q30 = 32'sd744261118;

  // Configuration codes of cost_mode
  typedef enum logic [1:0] {
    CM_NULL = 2'd0,
    CM_MSE  = 2'd1,
    CM_CE   = 2'd2,
    CM_RSV  = 2'd3
  } cost_mode_t;

  // Work class of one request after decode
  typedef enum logic [1:0] {
    CLS_NULL = 2'd0,
    CLS_MSE  = 2'd1,
    CLS_CE   = 2'd2
  } cls_t;

  // Decoded request as it sits in the queue
  typedef struct packed {
    cls_t               cls;
    logic               last;
    logic signed [15:0] tgt;
    logic signed [16:0] diff;
    logic signed [31:0] grad_dir;
    logic [31:0]        num_mag;
    logic [15:0]        den_mag;
    logic               grad_neg;
    logic [13:0]        lfrac;
    logic signed [4:0]  lexp;
  } item_t;

  // Queue status seen by the top level
  typedef struct packed {
    logic [1:0] count;
    logic       full;
    logic       empty;
  } queue_stat_t;

  // log2 of x0 * 2^-30 in Q0.16 by repeated squaring, x0 in [2^30, 2^31)
  function automatic logic [16:0] log2_sq(input logic [63:0] x0);
    logic [63:0] x;
    logic [16:0] r;
    x = x0;
    r = '0;
    for (int k = 0; k < 16; k++) begin
      x = (x * x) >> 30;
      r = {r[15:0], 1'b0};
      if (x >= (64'd2 << 30)) begin
        r[0] = 1'b1;
        x = x >> 1;
      end
    end
    return r;
  endfunction

  // Saturate a 49-bit signed value to 32 bits
  function automatic logic [31:0] sat32(input logic signed [48:0] v);
    if (v > 49'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end else if (v < -49'sd2147483648) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

endpackage

>>> design/lgs_front.sv
// Front decode: classifies a request and prepares divider and log operands.
module lgs_front (
  input  logic signed [15:0] pred,
  input  logic signed [15:0] tgt,
  input  logic               last,
  input  logic [1:0]         mode,
  output lgs_pkg::item_t     item
);

  logic signed [16:0] diff;
  logic signed [15:0] q;
  logic [15:0]        qmag;
  logic [15:0]        tmag;
  logic [14:0]        lq;
  logic [3:0]         msb;
  logic [14:0]        mn;

  // Difference and denominator clamp
  always_comb begin
    diff = 17'(pred) - 17'(tgt);
    q    = (pred == 16'sd0) ? 16'sd1 : pred;
    qmag = q[15] ? 16'(-q) : 16'(q);
    tmag = tgt[15] ? 16'(-tgt) : 16'(tgt);
  end

  // Leading one of the clamped log argument, mantissa fraction
  always_comb begin
    lq  = (pred <= 16'sd0) ? 15'd1 : pred[14:0];
    msb = '0;
    for (int b = 0; b < 15; b++) begin
      if (lq[b]) msb = 4'(b);
    end
    mn = 15'(lq << (4'd14 - msb));
  end

  // Pack the decoded request
  always_comb begin
    item.cls = lgs_pkg::CLS_NULL;
    case (lgs_pkg::cost_mode_t'(mode))
      lgs_pkg::CM_MSE: item.cls = lgs_pkg::CLS_MSE;
      lgs_pkg::CM_CE:  item.cls = lgs_pkg::CLS_CE;
      default:         item.cls = lgs_pkg::CLS_NULL;
    endcase
    item.last     = last;
    item.tgt      = tgt;
    item.diff     = diff;
    item.grad_dir = (item.cls == lgs_pkg::CLS_MSE) ? {{13{diff[16]}}, diff, 2'b00}
                                                   : {{14{pred[15]}}, pred, 2'b00};
    item.num_mag  = {tmag, 16'd0};
    item.den_mag  = qmag;
    // sign of -t / q
    item.grad_neg = (tgt > 16'sd0) ^ q[15];
    item.lfrac    = mn[13:0];
    item.lexp     = $signed(5'({1'b0, msb}) - 5'd14);
  end

endmodule

>>> design/lgs_queue.sv
// Two-entry queue between front decode and back engine.
module lgs_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  lgs_pkg::item_t         push_item,
  input  logic                   pop,
  output lgs_pkg::item_t         head,
  output lgs_pkg::queue_stat_t   stat
);

  lgs_pkg::item_t mem_r [2];
  logic           wp_r;
  logic           rp_r;
  logic [1:0]     cnt_r;

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_item;
    end
  end

  // Pointers and fill
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  assign head       = mem_r[rp_r];
  assign stat.count = cnt_r;
  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);

endmodule

>>> design/lgs_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module lgs_div #(
  parameter int NW = 48,
  parameter int DW = 24
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] quo_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [DW:0]   sh;
  logic          ge;
  logic [DW-1:0] rem_nxt;
  logic [NW-1:0] quo_nxt;

  // One shift-subtract step
  always_comb begin
    sh      = {rem_r, quo_r[NW-1]};
    ge      = (sh >= {1'b0, den_r});
    rem_nxt = ge ? DW'(sh - {1'b0, den_r}) : sh[DW-1:0];
    quo_nxt = {quo_r[NW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  // Step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      if (start) begin
        cnt_r  <= CW'(NW);
        busy_r <= 1'b1;
        done_r <= 1'b0;
      end else if (busy_r) begin
        cnt_r  <= cnt_r - CW'(1);
        busy_r <= (cnt_r != CW'(1));
        done_r <= (cnt_r == CW'(1));
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

>>> design/lgs_back.sv
// Back engine: log interpolation, loss accumulation, division and result register.
module lgs_back #(
  parameter int COUNT_BITS = lgs_pkg::COUNT_BITS_DEF,
  parameter int LOG_DEPTH  = lgs_pkg::LOG_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  lgs_pkg::item_t head,
  input  logic           q_empty,
  output logic           pop,
  output logic [31:0]    grad,
  output logic [31:0]    loss,
  output logic           loss_valid,
  output logic           out_valid,
  input  logic           out_ready
);

  localparam int AW  = $clog2(LOG_DEPTH + 1);
  localparam int PW  = 14 + AW;
  localparam int DW  = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam int AC  = lgs_pkg::ACC_W;
  localparam int TW  = lgs_pkg::TERM_W;
  localparam logic signed [AC:0] ACC_MAX = (49'sd1 <<< (AC - 1)) - 49'sd1;
  localparam logic signed [AC:0] ACC_MIN = -(49'sd1 <<< (AC - 1));

  typedef enum logic [10:0] {
    ST_IDLE = 11'b000_0000_0001,
    ST_ROM  = 11'b000_0000_0010,
    ST_INT  = 11'b000_0000_0100,
    ST_LN   = 11'b000_0000_1000,
    ST_TERM = 11'b000_0001_0000,
    ST_SQ   = 11'b000_0010_0000,
    ST_ACC  = 11'b000_0100_0000,
    ST_DIVG = 11'b000_1000_0000,
    ST_FIN  = 11'b001_0000_0000,
    ST_DIVL = 11'b010_0000_0000,
    ST_OUT  = 11'b100_0000_0000
  } back_state_t;

  back_state_t state_r, state_nxt;

  // log2 mantissa table, built at elaboration
  logic [16:0] rom [LOG_DEPTH + 1];
  for (genvar i = 0; i <= LOG_DEPTH; i++) begin : g_rom
    if (i == LOG_DEPTH) begin : g_top
      assign rom[i] = 17'h10000;
    end else begin : g_pt
      localparam logic [63:0] X0 = ((64'(LOG_DEPTH) + 64'(i)) << 30) / 64'(LOG_DEPTH);
      assign rom[i] = lgs_pkg::log2_sq(X0);
    end
  end

  lgs_pkg::item_t         it_r;
  logic [AW-1:0]          idx_r;
  logic [13:0]            rem_r;
  logic [16:0]            lo_r;
  logic [16:0]            hi_r;
  logic signed [21:0]     l2_r;
  logic signed [21:0]     ln_r;
  logic signed [TW-1:0]   term_r;
  logic signed [AC-1:0]   acc_r;
  logic [COUNT_BITS-1:0]  cnt_r;
  logic [31:0]            grad_r;
  logic [31:0]            loss_r;
  logic [31:0]            ograd_r;
  logic [31:0]            oloss_r;
  logic                   olast_r;
  logic                   ovalid_r;

  logic [PW-1:0]          pos;
  logic [30:0]            iprod;
  logic signed [21:0]     l2_nxt;
  logic signed [52:0]     lsum;
  logic signed [37:0]     tsum;
  logic signed [33:0]     ssum;
  logic signed [AC:0]     asum;
  logic signed [AC-1:0]   acc_nxt;
  logic [AC-1:0]          acc_mag;
  logic                   div_start;
  logic [AC-1:0]          div_num;
  logic [DW-1:0]          div_den;
  logic                   div_done;
  logic [AC-1:0]          div_quo;
  logic signed [AC:0]     quo_s;
  logic                   load_out;

  // Table address from the mantissa fraction of the queue head
  assign pos = PW'(head.lfrac) * PW'(LOG_DEPTH);

  // Datapath steps, one per state
  always_comb begin
    iprod  = 31'(hi_r - lo_r) * 31'(rem_r);
    l2_nxt = $signed({5'd0, lo_r}) + $signed({5'd0, iprod[30:14]})
           + $signed({it_r.lexp[4], it_r.lexp, 16'd0});
    lsum   = 53'(l2_r) * 53'(lgs_pkg::LN2_Q30) + (53'sd1 <<< 29);
    tsum   = 38'(it_r.tgt) * 38'(ln_r) + 38'sd8192;
    ssum   = 34'(it_r.diff) * 34'(it_r.diff) + 34'sd4096;
    asum   = 49'(acc_r) + 49'(term_r);
    if (asum > ACC_MAX) begin
      acc_nxt = ACC_MAX[AC-1:0];
    end else if (asum < ACC_MIN) begin
      acc_nxt = ACC_MIN[AC-1:0];
    end else begin
      acc_nxt = asum[AC-1:0];
    end
    acc_mag = acc_r[AC-1] ? AC'(-acc_r) : AC'(acc_r);
  end

  // Shared divider: gradient quotient, then tensor mean
  always_comb begin
    div_start = ((state_r == ST_ACC) && (it_r.cls == lgs_pkg::CLS_CE))
             || ((state_r == ST_FIN) && it_r.last && (it_r.cls == lgs_pkg::CLS_MSE));
    div_num   = (state_r == ST_ACC) ? AC'(it_r.num_mag) : acc_mag;
    div_den   = (state_r == ST_ACC) ? DW'(it_r.den_mag) : DW'(cnt_r);
    quo_s     = $signed({1'b0, div_quo});
  end

  lgs_div #(.NW(AC), .DW(DW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign pop      = (state_r == ST_IDLE) && !q_empty;
  assign load_out = (state_r == ST_OUT) && (!ovalid_r || out_ready);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          case (head.cls)
            lgs_pkg::CLS_CE:  state_nxt = ST_ROM;
            lgs_pkg::CLS_MSE: state_nxt = ST_SQ;
            default:          state_nxt = ST_FIN;
          endcase
        end
      end
      ST_ROM:  state_nxt = ST_INT;
      ST_INT:  state_nxt = ST_LN;
      ST_LN:   state_nxt = ST_TERM;
      ST_TERM: state_nxt = ST_ACC;
      ST_SQ:   state_nxt = ST_ACC;
      ST_ACC:  state_nxt = (it_r.cls == lgs_pkg::CLS_CE) ? ST_DIVG : ST_FIN;
      ST_DIVG: if (div_done) state_nxt = ST_FIN;
      ST_FIN:  state_nxt = (it_r.last && (it_r.cls == lgs_pkg::CLS_MSE)) ? ST_DIVL : ST_OUT;
      ST_DIVL: if (div_done) state_nxt = ST_OUT;
      ST_OUT:  if (load_out) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Working registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          it_r   <= head;
          grad_r <= head.grad_dir;
          idx_r  <= pos[PW-1:14];
          rem_r  <= pos[13:0];
        end
      end
      ST_ROM: begin
        lo_r <= rom[idx_r];
        hi_r <= rom[idx_r + AW'(1)];
      end
      ST_INT:  l2_r   <= l2_nxt;
      ST_LN:   ln_r   <= lsum[51:30];
      ST_TERM: term_r <= tsum[37:14];
      ST_SQ:   term_r <= $signed({3'd0, ssum[33:13]});
      ST_DIVG: begin
        if (div_done) begin
          grad_r <= lgs_pkg::sat32(it_r.grad_neg ? -quo_s : quo_s);
        end
      end
      ST_FIN: begin
        loss_r <= (it_r.last && (it_r.cls == lgs_pkg::CLS_CE))
                ? lgs_pkg::sat32(-49'(acc_r)) : '0;
      end
      ST_DIVL: begin
        if (div_done) begin
          loss_r <= lgs_pkg::sat32(acc_r[AC-1] ? -quo_s : quo_s);
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (load_out) begin
      ograd_r <= grad_r;
      oloss_r <= loss_r;
      olast_r <= it_r.last;
    end
  end

  // Control and tensor state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      acc_r    <= '0;
      cnt_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (pop && (cnt_r != {COUNT_BITS{1'b1}})) begin
        cnt_r <= cnt_r + COUNT_BITS'(1);
      end
      if (state_r == ST_ACC) begin
        acc_r <= acc_nxt;
      end
      if (load_out) begin
        ovalid_r <= 1'b1;
        if (it_r.last) begin
          acc_r <= '0;
          cnt_r <= '0;
        end
      end else if (out_ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  assign grad       = ograd_r;
  assign loss       = oloss_r;
  assign loss_valid = olast_r;
  assign out_valid  = ovalid_r;

endmodule

>>> design/loss_and_gradient_stream_top.sv
// Top level of the loss and gradient stream: config register, front, queue, back.
//
//  channel | dir | handshake          | payload
//  in_     | in  | in_tvalid/tready   | tdata: prediction, target; tlast: last
//  out_    | out | out_tvalid/tready  | tdata: gradient, loss; tlast: loss_valid
//  cfg_    | in  | cfg_we             | cfg_wdata: cost_mode
//
// The back engine works on one request at a time: null cost goes straight to the
// result, mean squared error squares and accumulates (plus a mean division on a last
// element), and cross entropy runs the log stages, accumulates and uses the bit-serial 48-step divider.
// Reset (rst_n low, synchronous) clears mode, accumulator, counter and queue.
// The two-entry queue takes requests while the back engine or the output stalls.
module loss_and_gradient_stream_top #(
  parameter int COUNT_BITS = lgs_pkg::COUNT_BITS_DEF,
  parameter int LOG_DEPTH  = lgs_pkg::LOG_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] prediction, [31:16] target
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [31:0] gradient, [63:32] loss
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata
);

  logic [1:0]            cost_mode_r;
  lgs_pkg::item_t        dec_item;
  lgs_pkg::item_t        head;
  lgs_pkg::queue_stat_t  q_stat;
  logic                  push;
  logic                  pop;
  logic [31:0]           grad;
  logic [31:0]           loss;

  // Cost mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cost_mode_r <= lgs_pkg::CM_NULL;
    end else if (cfg_we) begin
      cost_mode_r <= cfg_wdata;
    end
  end

  lgs_front u_front (
    .pred (in_tdata[15:0]),
    .tgt  (in_tdata[31:16]),
    .last (in_tlast),
    .mode (cost_mode_r),
    .item (dec_item)
  );

  assign in_tready = !q_stat.full;
  assign push      = in_tvalid && in_tready;

  lgs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (dec_item),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  lgs_back #(.COUNT_BITS(COUNT_BITS), .LOG_DEPTH(LOG_DEPTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_empty    (q_stat.empty),
    .pop        (pop),
    .grad       (grad),
    .loss       (loss),
    .loss_valid (out_tlast),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready)
  );

  assign out_tdata = {loss, grad};

  // Loss is zero except on the result of a last element
  a_loss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[63:32] == 32'd0)
    else $error("loss nonzero on a non-last result");

  // The back engine never pops an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  // A lone push grows the queue by one
  a_fill_track: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> q_stat.count == $past(q_stat.count) + 2'd1)
    else $error("queue fill count wrong after push");

endmodule
